// ===== rtl/quad_attitude_pid_mixer_core_assert.svh =====
// Assertion macros shared by the attitude controller RTL.
`ifndef QUAD_ATTITUDE_PID_MIXER_CORE_ASSERT_SVH
`define QUAD_ATTITUDE_PID_MIXER_CORE_ASSERT_SVH

// Check a consequence in the same cycle as its trigger.
`define QAPM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define QAPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/qapm_pkg.sv =====
// Shared types and constants of the attitude PID and motor mixer.
`timescale 1ns / 1ps

package qapm_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_KP_PR    = 3'd0;
    localparam logic [2:0] CFG_KI_PR    = 3'd1;
    localparam logic [2:0] CFG_KD_PR    = 3'd2;
    localparam logic [2:0] CFG_KP_YAW   = 3'd3;
    localparam logic [2:0] CFG_KI_YAW   = 3'd4;
    localparam logic [2:0] CFG_KD_YAW   = 3'd5;
    localparam logic [2:0] CFG_FAILSAFE = 3'd6;
    localparam logic [2:0] CFG_INT_LIM  = 3'd7;
    localparam int         CFG_NUM      = 8;
    localparam int         CFG_W        = 16;

    localparam logic [CFG_W-1:0] CFG_RESET [CFG_NUM] = '{
        16'd2048, 16'd0, 16'd410, 16'd1229, 16'd0, 16'd205, 16'd500, 16'd12800
    };

    // Drive status codes
    localparam logic [1:0] STAT_MIXED    = 2'd0;
    localparam logic [1:0] STAT_FAILSAFE = 2'd1;
    localparam logic [1:0] STAT_ZERO_THR = 2'd2;

    // Axis indexes
    localparam logic [1:0] AXIS_PITCH = 2'd0;
    localparam logic [1:0] AXIS_ROLL  = 2'd1;
    localparam logic [1:0] AXIS_YAW   = 2'd2;

    // Serial multiplier: signed multiplicand, unsigned multiplier bits
    localparam int MUL_A_W = 64;
    localparam int MUL_B_W = 20;
    localparam int MUL_CNT_W = 5;

    // Serial divider: dividend magnitude bits, divisor bits
    localparam int DIV_N_W = 48;
    localparam int DIV_D_W = 20;
    localparam int DIV_CNT_W = 6;
    localparam int QUOT_W = 11;

    // Scaling of the fixed-point sum: 2^(gain frac + angle frac)
    localparam int SUM_SHIFT = 12 + 7;

    // Constant multipliers
    localparam logic [MUL_B_W-1:0] K_MS_PER_S = 20'd1000;
    localparam logic [MUL_B_W-1:0] K_MS2      = 20'd1000000;

    // floor(x/100) for x below 2^15 as (x*5243) >> 19
    localparam logic [12:0] BASE_RECIP = 13'd5243;
    localparam int          BASE_SHIFT = 19;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ===== rtl/qapm_mul.sv =====
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier.
`timescale 1ns / 1ps

module qapm_mul (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [qapm_pkg::MUL_A_W-1:0]    a,
    input  logic        [qapm_pkg::MUL_B_W-1:0]    b,
    output logic signed [qapm_pkg::MUL_A_W-1:0]    prod,
    output qapm_pkg::unit_stat_t                   st
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [qapm_pkg::MUL_CNT_W-1:0]      cnt_reg, cnt_next;
    logic signed [qapm_pkg::MUL_A_W-1:0] a_reg, a_next;
    logic        [qapm_pkg::MUL_B_W-1:0] b_reg, b_next;
    logic signed [qapm_pkg::MUL_A_W-1:0] prod_reg, prod_next;

    // One multiplier bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        prod_next = prod_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = a;
            b_next    = b;
            prod_next = '0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                prod_next = prod_reg + a_reg;
            end
            a_next   = a_reg <<< 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == qapm_pkg::MUL_CNT_W'(qapm_pkg::MUL_B_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
    end

    assign prod    = prod_reg;
    assign st.busy = busy_reg;
    assign st.done = done_reg;

endmodule

// ===== rtl/qapm_div.sv =====
// Bit-serial restoring divider giving a saturated floor quotient.
`timescale 1ns / 1ps

module qapm_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [63:0]                    x,
    input  logic        [qapm_pkg::DIV_D_W-1:0]   d,
    output logic signed [qapm_pkg::QUOT_W-1:0]    quot,
    output qapm_pkg::unit_stat_t                  st
);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [qapm_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [qapm_pkg::DIV_N_W-1:0]       n_reg, n_next;
    logic [qapm_pkg::DIV_D_W-1:0]       r_reg, r_next;
    logic [qapm_pkg::DIV_D_W-1:0]       d_reg, d_next;
    logic                               neg_reg, neg_next;

    logic [63:0]                        mag;
    logic [qapm_pkg::DIV_D_W:0]         r_sh;
    logic [qapm_pkg::DIV_D_W:0]         r_sub;
    logic                               ge;
    logic                               big;
    logic [9:0]                         qmag;

    // Shift one dividend bit into the remainder per cycle
    always_comb
    begin
        mag       = x[63] ? (64'd0 - x) : x;
        r_sh      = {r_reg, n_reg[qapm_pkg::DIV_N_W-1]};
        ge        = (r_sh >= {1'b0, d_reg});
        r_sub     = r_sh - {1'b0, d_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            n_next    = mag[qapm_pkg::DIV_N_W-1:0];
            r_next    = '0;
            d_next    = d;
            neg_next  = x[63];
        end
        else if (busy_reg)
        begin
            r_next   = ge ? r_sub[qapm_pkg::DIV_D_W-1:0] : r_sh[qapm_pkg::DIV_D_W-1:0];
            n_next   = {n_reg[qapm_pkg::DIV_N_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == qapm_pkg::DIV_CNT_W'(qapm_pkg::DIV_N_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Round toward minus infinity and saturate to the useful range
    always_comb
    begin
        big = |n_reg[qapm_pkg::DIV_N_W-1:9];
        if (neg_reg)
        begin
            qmag = big ? 10'd512 : ({1'b0, n_reg[8:0]} + {9'd0, (r_reg != '0)});
            quot = $signed(11'd0 - {1'b0, qmag});
        end
        else
        begin
            qmag = big ? 10'd511 : {1'b0, n_reg[8:0]};
            quot = $signed({1'b0, qmag});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign st.busy = busy_reg;
    assign st.done = done_reg;

endmodule

// ===== rtl/quad_attitude_pid_mixer_core.sv =====
// Top level: three PID loops and an X-frame motor mixer on serial arithmetic.
//
//  channel  | dir | handshake               | contents
//  s_axis   | in  | tvalid/tready           | one control tick
//  m_axis   | out | tvalid/tready           | four motor duties and drive status
//  cfg      | in  | cfg_we                  | gain, failsafe and clamp registers
//
// A tick that drives the motors is accepted, then per axis runs a setup state and 7
// products on the 20-step shift-add multiplier, then 4 quotients on the 48-step divider,
// and finally loads the output. Failsafe and zero-throttle ticks go straight to the output
// load; a tick with no fresh packet is accepted and dropped with no result.
// Input is taken only while idle; a finished result waits in the output register
// while the next tick runs. Reset clears integrals and previous errors at once.
`timescale 1ns / 1ps
`include "quad_attitude_pid_mixer_core_assert.svh"

module quad_attitude_pid_mixer_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // ms_since_packet[15:0], tick_ms[25:16], throttle_pct[32:26],
    // set_pitch[48:33], set_roll[64:49], set_yaw[80:65], meas_pitch[96:81],
    // meas_roll[112:97], meas_yaw[128:113], zeros[135:129]
    input  logic [135:0]   s_axis_tdata,
    // packet_fresh[0]
    input  logic [0:0]     s_axis_tuser,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // motor_front_left[7:0], motor_front_right[15:8], motor_rear_left[23:16],
    // motor_rear_right[31:24]
    output logic [31:0]    m_axis_tdata,
    // drive_status[1:0]
    output logic [1:0]     m_axis_tuser,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_index,
    input  logic [15:0]    cfg_wdata
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_E    = 4'd1;
    localparam logic [3:0] S_M_ED = 4'd2;
    localparam logic [3:0] S_M_T1 = 4'd3;
    localparam logic [3:0] S_M_P  = 4'd4;
    localparam logic [3:0] S_M_T2 = 4'd5;
    localparam logic [3:0] S_M_I  = 4'd6;
    localparam logic [3:0] S_M_T3 = 4'd7;
    localparam logic [3:0] S_M_D  = 4'd8;
    localparam logic [3:0] S_MIX  = 4'd9;
    localparam logic [3:0] S_DIV  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    // Control state
    logic [3:0]          state_reg, state_next;
    logic [1:0]          axis_reg, axis_next;
    logic [1:0]          mot_reg, mot_next;
    logic                out_valid_reg, out_valid_next;
    logic [15:0]         cfg_reg [qapm_pkg::CFG_NUM];
    logic [15:0]         cfg_next [qapm_pkg::CFG_NUM];
    logic signed [31:0]  integ_reg [3];
    logic signed [31:0]  integ_next [3];
    logic signed [16:0]  prev_reg [3];
    logic signed [16:0]  prev_next [3];

    // Payload
    logic signed [15:0]  set_reg [3];
    logic signed [15:0]  set_next [3];
    logic signed [15:0]  meas_reg [3];
    logic signed [15:0]  meas_next [3];
    logic [9:0]          dt_reg, dt_next;
    logic [19:0]         dms_reg, dms_next;
    logic [8:0]          base_reg, base_next;
    logic signed [16:0]  e_reg, e_next;
    logic signed [17:0]  de_reg, de_next;
    logic signed [31:0]  acc_reg, acc_next;
    logic signed [63:0]  sum_reg, sum_next;
    logic signed [63:0]  axo_reg [3];
    logic signed [63:0]  axo_next [3];
    logic [7:0]          res_reg [4];
    logic [7:0]          res_next [4];
    logic [1:0]          stat_reg, stat_next;
    logic [31:0]         out_data_reg, out_data_next;
    logic [1:0]          out_user_reg, out_user_next;

    // Unit hookup
    logic                mul_start;
    logic signed [63:0]  mul_a;
    logic [19:0]         mul_b;
    logic signed [63:0]  mul_prod;
    qapm_pkg::unit_stat_t mul_st;
    logic                div_start;
    logic signed [63:0]  div_x;
    logic signed [10:0]  div_quot;
    qapm_pkg::unit_stat_t div_st;

    logic                s_accept;
    logic                failsafe_hit;

    qapm_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_prod),
        .st    (mul_st)
    );

    qapm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .x     (div_x),
        .d     (dms_reg),
        .quot  (div_quot),
        .st    (div_st)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign failsafe_hit  = (s_axis_tdata[15:0] > cfg_reg[qapm_pkg::CFG_FAILSAFE]);

    // Sequence the three loops and the four motor quotients
    always_comb
    begin
        logic [9:0]          tick;
        logic [6:0]          thr;
        logic [14:0]         thr255;
        logic [27:0]         bprod;
        logic [25:0]         lim;
        logic signed [33:0]  lim_s;
        logic signed [33:0]  accsum;
        logic signed [31:0]  acc_c;
        logic signed [16:0]  e_c;
        logic [15:0]         kp;
        logic [15:0]         ki;
        logic [15:0]         kd;
        logic signed [63:0]  mix;
        logic signed [11:0]  v;

        tick   = s_axis_tdata[25:16];
        thr    = s_axis_tdata[32:26];
        thr255 = {thr, 8'd0} - {8'd0, thr};
        bprod  = {13'd0, thr255} * {15'd0, qapm_pkg::BASE_RECIP};
        lim    = {cfg_reg[qapm_pkg::CFG_INT_LIM], 10'd0}
               - {6'd0, cfg_reg[qapm_pkg::CFG_INT_LIM], 4'd0}
               - {7'd0, cfg_reg[qapm_pkg::CFG_INT_LIM], 3'd0};
        lim_s  = $signed({8'd0, lim});
        accsum = $signed({{2{integ_reg[axis_reg][31]}}, integ_reg[axis_reg]})
               + $signed(mul_prod[33:0]);
        if (accsum > lim_s)
        begin
            acc_c = lim_s[31:0];
        end
        else if (accsum < -lim_s)
        begin
            acc_c = 32'(-lim_s);
        end
        else
        begin
            acc_c = accsum[31:0];
        end
        e_c = $signed({set_reg[axis_reg][15], set_reg[axis_reg]})
            - $signed({meas_reg[axis_reg][15], meas_reg[axis_reg]});
        kp  = (axis_reg == qapm_pkg::AXIS_YAW) ? cfg_reg[qapm_pkg::CFG_KP_YAW]
                                               : cfg_reg[qapm_pkg::CFG_KP_PR];
        ki  = (axis_reg == qapm_pkg::AXIS_YAW) ? cfg_reg[qapm_pkg::CFG_KI_YAW]
                                               : cfg_reg[qapm_pkg::CFG_KI_PR];
        kd  = (axis_reg == qapm_pkg::AXIS_YAW) ? cfg_reg[qapm_pkg::CFG_KD_YAW]
                                               : cfg_reg[qapm_pkg::CFG_KD_PR];
        unique case (mot_reg)
            2'd0:    mix = axo_reg[0] - axo_reg[1] - axo_reg[2];
            2'd1:    mix = axo_reg[0] + axo_reg[1] + axo_reg[2];
            2'd2:    mix = axo_reg[2] - axo_reg[0] - axo_reg[1];
            default: mix = axo_reg[1] - axo_reg[0] - axo_reg[2];
        endcase
        v = $signed({3'd0, base_reg}) + $signed({div_quot[10], div_quot});

        state_next     = state_reg;
        axis_next      = axis_reg;
        mot_next       = mot_reg;
        out_valid_next = out_valid_reg;
        cfg_next       = cfg_reg;
        integ_next     = integ_reg;
        prev_next      = prev_reg;
        set_next       = set_reg;
        meas_next      = meas_reg;
        dt_next        = dt_reg;
        dms_next       = dms_reg;
        base_next      = base_reg;
        e_next         = e_reg;
        de_next        = de_reg;
        acc_next       = acc_reg;
        sum_next       = sum_reg;
        axo_next       = axo_reg;
        res_next       = res_reg;
        stat_next      = stat_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        mul_start      = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        div_x          = '0;

        // Write a configuration register
        if (cfg_we)
        begin
            cfg_next[cfg_index] = cfg_wdata;
        end

        // Drop the output once taken
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    dt_next      = (tick == 10'd0) ? 10'd1 : tick;
                    dms_next     = {dt_next, 10'd0} - {6'd0, dt_next, 4'd0}
                                 - {7'd0, dt_next, 3'd0};
                    base_next    = bprod[qapm_pkg::BASE_SHIFT +: 9];
                    set_next[0]  = s_axis_tdata[48:33];
                    set_next[1]  = s_axis_tdata[64:49];
                    set_next[2]  = s_axis_tdata[80:65];
                    meas_next[0] = s_axis_tdata[96:81];
                    meas_next[1] = s_axis_tdata[112:97];
                    meas_next[2] = s_axis_tdata[128:113];
                    res_next     = '{default: 8'd0};
                    if (failsafe_hit)
                    begin
                        stat_next  = qapm_pkg::STAT_FAILSAFE;
                        integ_next = '{default: 32'sd0};
                        state_next = S_OUT;
                    end
                    else if (s_axis_tuser[0] && (thr == 7'd0))
                    begin
                        stat_next  = qapm_pkg::STAT_ZERO_THR;
                        integ_next = '{default: 32'sd0};
                        state_next = S_OUT;
                    end
                    else if (s_axis_tuser[0])
                    begin
                        stat_next  = qapm_pkg::STAT_MIXED;
                        axis_next  = qapm_pkg::AXIS_PITCH;
                        state_next = S_E;
                    end
                end
            end
            S_E:
            begin
                e_next     = e_c;
                de_next    = $signed({e_c[16], e_c})
                           - $signed({prev_reg[axis_reg][16], prev_reg[axis_reg]});
                sum_next   = '0;
                mul_start  = 1'b1;
                mul_a      = {{47{e_c[16]}}, e_c};
                mul_b      = {10'd0, dt_reg};
                state_next = S_M_ED;
            end
            S_M_ED:
            begin
                if (mul_st.done)
                begin
                    integ_next[axis_reg] = acc_c;
                    prev_next[axis_reg]  = e_reg;
                    acc_next             = acc_c;
                    mul_start            = 1'b1;
                    mul_a                = mul_prod;
                    mul_b                = qapm_pkg::K_MS_PER_S;
                    state_next           = S_M_T1;
                end
            end
            S_M_T1:
            begin
                if (mul_st.done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = mul_prod;
                    mul_b      = {4'd0, kp};
                    state_next = S_M_P;
                end
            end
            S_M_P:
            begin
                if (mul_st.done)
                begin
                    sum_next   = sum_reg + mul_prod;
                    mul_start  = 1'b1;
                    mul_a      = {{32{acc_reg[31]}}, acc_reg};
                    mul_b      = {10'd0, dt_reg};
                    state_next = S_M_T2;
                end
            end
            S_M_T2:
            begin
                if (mul_st.done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = mul_prod;
                    mul_b      = {4'd0, ki};
                    state_next = S_M_I;
                end
            end
            S_M_I:
            begin
                if (mul_st.done)
                begin
                    sum_next   = sum_reg + mul_prod;
                    mul_start  = 1'b1;
                    mul_a      = {{46{de_reg[17]}}, de_reg};
                    mul_b      = {4'd0, kd};
                    state_next = S_M_T3;
                end
            end
            S_M_T3:
            begin
                if (mul_st.done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = mul_prod;
                    mul_b      = qapm_pkg::K_MS2;
                    state_next = S_M_D;
                end
            end
            S_M_D:
            begin
                if (mul_st.done)
                begin
                    axo_next[axis_reg] = sum_reg + mul_prod;
                    if (axis_reg == qapm_pkg::AXIS_YAW)
                    begin
                        mot_next   = 2'd0;
                        state_next = S_MIX;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_E;
                    end
                end
            end
            S_MIX:
            begin
                div_start  = 1'b1;
                div_x      = mix >>> qapm_pkg::SUM_SHIFT;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_st.done)
                begin
                    if (v < 12'sd0)
                    begin
                        res_next[mot_reg] = 8'd0;
                    end
                    else if (v > 12'sd255)
                    begin
                        res_next[mot_reg] = 8'd255;
                    end
                    else
                    begin
                        res_next[mot_reg] = v[7:0];
                    end
                    if (mot_reg == 2'd3)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        mot_next   = mot_reg + 2'd1;
                        state_next = S_MIX;
                    end
                end
            end
            S_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = {res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
                    out_user_next  = stat_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= qapm_pkg::AXIS_PITCH;
            mot_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
            cfg_reg       <= qapm_pkg::CFG_RESET;
            integ_reg     <= '{default: 32'sd0};
            prev_reg      <= '{default: 17'sd0};
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            mot_reg       <= mot_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
            integ_reg     <= integ_next;
            prev_reg      <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_reg      <= set_next;
        meas_reg     <= meas_next;
        dt_reg       <= dt_next;
        dms_reg      <= dms_next;
        base_reg     <= base_next;
        e_reg        <= e_next;
        de_reg       <= de_next;
        acc_reg      <= acc_next;
        sum_reg      <= sum_next;
        axo_reg      <= axo_next;
        res_reg      <= res_next;
        stat_reg     <= stat_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    `QAPM_ASSERT_NOW(a_mul_start_idle, mul_start, !mul_st.busy,
        "multiplier started while busy")
    `QAPM_ASSERT_NOW(a_div_start_idle, div_start, !div_st.busy,
        "divider started while busy")
    `QAPM_ASSERT_NOW(a_off_motors_zero,
        m_axis_tvalid && (m_axis_tuser != qapm_pkg::STAT_MIXED),
        m_axis_tdata == 32'd0, "motors not off with drive off")
    `QAPM_ASSERT_NEXT(a_failsafe_clears, s_accept && failsafe_hit,
        (state_reg == S_OUT) && (integ_reg[0] == 32'sd0) && (integ_reg[2] == 32'sd0),
        "failsafe did not clear")
    `QAPM_ASSERT_NOW(a_axis_range, state_reg != S_IDLE,
        axis_reg <= qapm_pkg::AXIS_YAW, "axis index out of range")

endmodule

// ===== tb/quad_attitude_pid_mixer_core_tb.sv =====
// Self-checking testbench for the quadcopter attitude PID and X-frame motor mixer.
`timescale 1ns / 1ps

module quad_attitude_pid_mixer_core_tb;

    typedef struct packed {
        logic        fresh;
        logic [15:0] since;
        logic [9:0]  tick;
        logic [6:0]  thr;
        logic signed [15:0] sp_pitch, sp_roll, sp_yaw, ms_pitch, ms_roll, ms_yaw;
    } tick_t;

    typedef struct packed {
        logic [7:0] fl, fr, rl, rr;
        logic [1:0] status;
    } duty_t;

    localparam int LIMIT_CYCLES = 4000000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic [0:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [31:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [15:0]  cfg_wdata = '0;

    quad_attitude_pid_mixer_core dut (.*);

    always #1 clk = ~clk;

    // Predictor state
    logic [15:0] gain_reg [qapm_pkg::CFG_NUM];
    longint      integ [3];
    longint      prev_err [3];

    tick_t  pending_ticks [$];
    duty_t  expected_duties [$];
    int     errors = 0;
    int     results_seen = 0;
    int     n_failsafe = 0, n_zero_thr = 0, n_mixed = 0, n_stale = 0;
    longint cycles = 0;
    int     hold_rx_cycles = 0;

    function automatic longint pid_axis(int ax, longint sp, longint ms, longint dt,
                                        longint kp, longint ki, longint kd);
        longint e, lim, acc, de;
        e   = sp - ms;
        lim = longint'(gain_reg[qapm_pkg::CFG_INT_LIM]) * 1000;
        acc = integ[ax] + e * dt;
        if (acc > lim) acc = lim;
        if (acc < -lim) acc = -lim;
        integ[ax] = acc;
        de = e - prev_err[ax];
        prev_err[ax] = e;
        return kp * e * 1000 * dt + ki * acc * dt + kd * de * 1000000;
    endfunction

    function automatic logic [7:0] sat_duty(longint num, longint den);
        if (num <= 0) return 8'd0;
        if (num >= 255 * den) return 8'd255;
        return 8'(num / den);
    endfunction

    // Advance the predicted controller by one tick; returns 1 when a result is due
    function automatic bit predict_motors(tick_t t, output duty_t d);
        longint dt, den, base, p, r, y;
        dt = (t.tick == 0) ? 1 : longint'(t.tick);
        d = '0;
        if (t.since > gain_reg[qapm_pkg::CFG_FAILSAFE])
        begin
            integ = '{0, 0, 0};
            d.status = qapm_pkg::STAT_FAILSAFE;
            return 1;
        end
        if (!t.fresh) return 0;
        if (t.thr == 0)
        begin
            integ = '{0, 0, 0};
            d.status = qapm_pkg::STAT_ZERO_THR;
            return 1;
        end
        p = pid_axis(qapm_pkg::AXIS_PITCH, t.sp_pitch, t.ms_pitch, dt,
                     gain_reg[qapm_pkg::CFG_KP_PR], gain_reg[qapm_pkg::CFG_KI_PR],
                     gain_reg[qapm_pkg::CFG_KD_PR]);
        r = pid_axis(qapm_pkg::AXIS_ROLL, t.sp_roll, t.ms_roll, dt,
                     gain_reg[qapm_pkg::CFG_KP_PR], gain_reg[qapm_pkg::CFG_KI_PR],
                     gain_reg[qapm_pkg::CFG_KD_PR]);
        y = pid_axis(qapm_pkg::AXIS_YAW, t.sp_yaw, t.ms_yaw, dt,
                     gain_reg[qapm_pkg::CFG_KP_YAW], gain_reg[qapm_pkg::CFG_KI_YAW],
                     gain_reg[qapm_pkg::CFG_KD_YAW]);
        den  = 1000 * dt * (longint'(1) << qapm_pkg::SUM_SHIFT);
        base = longint'((int'(t.thr) * 255) / 100) * den;
        d.fl = sat_duty(base + p - r - y, den);
        d.fr = sat_duty(base + p + r + y, den);
        d.rl = sat_duty(base - p - r + y, den);
        d.rr = sat_duty(base - p + r - y, den);
        d.status = qapm_pkg::STAT_MIXED;
        return 1;
    endfunction

    // Driver: pop queued ticks, random gap before each, predict on acceptance
    int tx_gap = 0;
    always @(posedge clk)
    begin
        duty_t d;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (predict_motors(pending_ticks[0], d)) expected_duties.push_back(d);
                else n_stale++;
                void'(pending_ticks.pop_front());
                tx_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 10);
            end
            if ((!s_axis_tvalid || s_axis_tready) && tx_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                tx_gap = tx_gap - 1;
            end
            else if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_ticks.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= pending_ticks[0].fresh;
                    s_axis_tdata  <= {7'd0, pending_ticks[0].ms_yaw, pending_ticks[0].ms_roll,
                                      pending_ticks[0].ms_pitch, pending_ticks[0].sp_yaw,
                                      pending_ticks[0].sp_roll, pending_ticks[0].sp_pitch,
                                      pending_ticks[0].thr, pending_ticks[0].tick,
                                      pending_ticks[0].since};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest prediction
    int rx_gap = 0;
    always @(posedge clk)
    begin
        duty_t got, want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                       m_axis_tdata[31:24], m_axis_tuser};
                results_seen++;
                if (expected_duties.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                end
                else
                begin
                    want = expected_duties.pop_front();
                    case (want.status)
                        qapm_pkg::STAT_FAILSAFE: n_failsafe++;
                        qapm_pkg::STAT_ZERO_THR: n_zero_thr++;
                        default:                 n_mixed++;
                    endcase
                    if (got.fl !== want.fl || got.fr !== want.fr || got.rl !== want.rl ||
                        got.rr !== want.rr || got.status !== want.status)
                    begin
                        errors++;
                        $display({"%0t: mismatch fl/fr/rl/rr/status expected ",
                                  "%0d/%0d/%0d/%0d/%0d actual %0d/%0d/%0d/%0d/%0d"},
                                 $time, want.fl, want.fr, want.rl, want.rr, want.status,
                                 got.fl, got.fr, got.rl, got.rr, got.status);
                    end
                end
                rx_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 10);
            end
            if (hold_rx_cycles > 0)
            begin
                hold_rx_cycles--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'(16'($urandom));
            default: return 16'($signed($urandom_range(0, 46080)) - 23040);
        endcase
    endfunction

    function automatic tick_t rand_tick();
        tick_t t;
        t.fresh = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 19))
            0: t.since = 16'($urandom);
            1: t.since = 16'hFFFF;
            default: t.since = 16'($urandom_range(0, 40));
        endcase
        case ($urandom_range(0, 9))
            0: t.tick = 10'd0;
            1: t.tick = 10'($urandom);
            default: t.tick = 10'($urandom_range(1, 20));
        endcase
        case ($urandom_range(0, 19))
            0: t.thr = 7'd0;
            1: t.thr = 7'($urandom_range(101, 127));
            default: t.thr = 7'($urandom_range(1, 100));
        endcase
        t.sp_pitch = rand_angle(); t.sp_roll = rand_angle(); t.sp_yaw = rand_angle();
        t.ms_pitch = rand_angle(); t.ms_roll = rand_angle(); t.ms_yaw = rand_angle();
        return t;
    endfunction

    task automatic wait_drained();
        while (pending_ticks.size() > 0 || s_axis_tvalid || expected_duties.size() > 0)
            @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        gain_reg[idx] = val;
        @(posedge clk);
    endtask

    function automatic tick_t mk(bit f, int since, int tk, int thr,
                                 int a, int b, int c, int d, int e, int g);
        tick_t t;
        t = '{f, 16'(since), 10'(tk), 7'(thr), 16'(a), 16'(b), 16'(c), 16'(d), 16'(e), 16'(g)};
        return t;
    endfunction

    initial
    begin
        logic [15:0] v;
        for (int i = 0; i < qapm_pkg::CFG_NUM; i++) gain_reg[i] = qapm_pkg::CFG_RESET[i];
        integ = '{0, 0, 0};
        prev_err = '{0, 0, 0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: defaults, extremes, each special case
        pending_ticks.push_back(mk(1, 0, 10, 50, 128, -128, 256, 0, 0, 0));
        pending_ticks.push_back(mk(1, 0, 0, 100, 23040, -23040, 23040, -23040, 23040, -23040));
        pending_ticks.push_back(mk(1, 0, 1023, 127, -32768, 32767, -32768, 32767, -32768, 32767));
        pending_ticks.push_back(mk(1, 501, 5, 50, 0, 0, 0, 0, 0, 0));
        pending_ticks.push_back(mk(0, 65535, 5, 50, 0, 0, 0, 0, 0, 0));
        pending_ticks.push_back(mk(0, 10, 5, 50, 1000, 0, 0, 0, 0, 0));
        pending_ticks.push_back(mk(1, 500, 5, 0, 1000, 0, 0, 0, 0, 0));
        pending_ticks.push_back(mk(1, 0, 1, 1, 32767, 32767, 32767, -32768, -32768, -32768));
        pending_ticks.push_back(mk(1, 0, 1000, 100, -1, 1, -1, 1, -1, 1));
        wait_drained();

        // Extreme gains
        for (int i = 0; i < 6; i++) write_reg(3'(i), 16'hFFFF);
        write_reg(qapm_pkg::CFG_FAILSAFE, 16'd1);
        write_reg(qapm_pkg::CFG_INT_LIM, 16'hFFFF);
        pending_ticks.push_back(mk(1, 1, 1023, 127, 32767, -32768, 32767, -32768, 32767, -32768));
        pending_ticks.push_back(mk(1, 2, 3, 60, 0, 0, 0, 0, 0, 0));
        pending_ticks.push_back(mk(1, 0, 1023, 100, 300, -300, 300, 0, 0, 0));
        wait_drained();
        for (int i = 0; i < 6; i++) write_reg(3'(i), 16'd0);
        write_reg(qapm_pkg::CFG_INT_LIM, 16'd0);
        pending_ticks.push_back(mk(1, 0, 7, 77, 1000, -1000, 500, 0, 0, 0));
        wait_drained();

        // Random phases with fresh register settings
        for (int ph = 0; ph < 10; ph++)
        begin
            for (int i = 0; i < qapm_pkg::CFG_NUM; i++)
            begin
                case ($urandom_range(0, 3))
                    0: v = 16'($urandom);
                    1: v = (i == qapm_pkg::CFG_FAILSAFE) ? 16'hFFFF : 16'd0;
                    default: v = (i == qapm_pkg::CFG_FAILSAFE) ? 16'($urandom_range(1, 60))
                                                               : 16'($urandom_range(0, 4096));
                endcase
                if (i == qapm_pkg::CFG_FAILSAFE && v == 0) v = 16'd1;
                write_reg(3'(i), v);
            end
            for (int k = 0; k < 110; k++) pending_ticks.push_back(rand_tick());
            if (ph == 3)
            begin
                // Stall the receiver long enough that the block fills and backs up
                hold_rx_cycles = 3000;
            end
            wait_drained();
        end

        $display("Covered %0d results: %0d mixed, %0d failsafe, %0d zero throttle;",
                 results_seen, n_mixed, n_failsafe, n_zero_thr);
        $display("%0d stale ticks dropped, one long receiver stall.", n_stale);
        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
